// ----- rtl/itohc_pkg.sv -----
// Package for the inactivity timer with hot corners.
// Holds the field widths, register indexes and outcome codes.
// No dependencies; used by the top level and its checker.
`default_nettype none

package itohc_pkg;

    // Default width of the wall clock in seconds.
    localparam int TIME_BITS_DEFAULT = 32;

    // Field widths of the input beat.
    localparam int NOW_IN_W  = 32;
    localparam int COORD_W   = 16;
    localparam int MASK_W    = 16;
    localparam int S_DATA_W  = 88;
    localparam int M_DATA_W  = 8;

    // Configuration register widths.
    localparam int IDLE_W    = 17;
    localparam int CSIZE_W   = 12;
    localparam int CDELAY_W  = 12;
    localparam int SCREEN_W  = 15;
    localparam int ACTIONS_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    // Clock jump limits in seconds.
    localparam int JUMP_FWD  = 120;
    localparam int JUMP_BACK = 121;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_LIMIT     = 3'd0,
        CFG_HOT_SPAN       = 3'd1,
        CFG_REST_DELAY     = 3'd2,
        CFG_SCREEN_WIDTH   = 3'd3,
        CFG_SCREEN_HEIGHT  = 3'd4,
        CFG_CORNER_ACTIONS = 3'd5
    } cfg_index_t;

    // Outcome codes of a result beat.
    typedef enum logic [1:0] {
        OUT_WAIT    = 2'd0,
        OUT_TIMEOUT = 2'd1,
        OUT_LOCK    = 2'd2,
        OUT_SAVE    = 2'd3
    } outcome_t;

    // Per-corner action codes.
    localparam logic [1:0] ACT_LOCK = 2'd1;
    localparam logic [1:0] ACT_SAVE = 2'd2;

    // Request kinds carried in tuser.
    localparam logic REQ_START = 1'b0;

endpackage

`default_nettype wire

// ----- rtl/idle_timeout_with_hot_corners_unit.sv -----
// Top level of the inactivity timer with hot corners.
// Depends on itohc_pkg for widths, register indexes and outcome codes.
// The checker in itohc_checker.sv is bound to this module.
`default_nettype none

// The block takes one beat per clock cycle while the input side is not stalled and
// returns one result beat for every input beat. A beat is captured in the input
// register, then passes through the decision logic into the result register once
// that register is free or being emptied, and its result is presented from there.
// A start beat arms the timer; each poll beat while armed may end the wait with a
// lock, a corner action or a timeout, and any end disarms it. Back-pressure on the
// result side stalls the input side only once both the input register and the
// result register are full.
// Configuration writes are always taken and should be issued only while the
// block is idle.
module idle_timeout_with_hot_corners_unit #(
    parameter int TIME_BITS = itohc_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata from bit 0 up: now_seconds[31:0], key_activity, lock_request,
    // pointer_x[15:0], pointer_y[15:0], modifier_mask[15:0], zero fill.
    input  wire logic [itohc_pkg::S_DATA_W-1:0]    s_tdata,
    // tuser: req_type.
    input  wire logic                              s_tuser,
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata from bit 0 up: outcome[1:0], zero fill.
    output logic [itohc_pkg::M_DATA_W-1:0]         m_tdata,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [itohc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [itohc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import itohc_pkg::*;

    // Effective clock width and deadline width.
    localparam int NOW_W = (TIME_BITS < NOW_IN_W) ? TIME_BITS : NOW_IN_W;
    localparam int DL_W  = ((NOW_W > IDLE_W) ? NOW_W : IDLE_W) + 1;
    localparam int RS_W  = DL_W + 1;
    localparam int XC_W  = SCREEN_W + 3;

    // Configuration registers.
    logic [IDLE_W-1:0]    idle_limit_reg;
    logic [CSIZE_W-1:0]   hot_span_reg;
    logic [CDELAY_W-1:0]  rest_delay_reg;
    logic [SCREEN_W-1:0]  screen_width_reg;
    logic [SCREEN_W-1:0]  screen_height_reg;
    logic [ACTIONS_W-1:0] corner_actions_reg;

    // Timer state.
    logic                 armed_reg, armed_next;
    logic [DL_W-1:0]      deadline_reg, deadline_next;
    logic [COORD_W-1:0]   last_x_reg, last_x_next;
    logic [COORD_W-1:0]   last_y_reg, last_y_next;
    logic [MASK_W-1:0]    last_mask_reg, last_mask_next;
    logic [NOW_W-1:0]     last_time_reg, last_time_next;

    // Input register.
    logic                 in_valid_reg;
    logic                 req_type_reg;
    logic [NOW_W-1:0]     now_reg;
    logic                 key_reg;
    logic                 force_reg;
    logic [COORD_W-1:0]   x_reg;
    logic [COORD_W-1:0]   y_reg;
    logic [MASK_W-1:0]    mask_reg;

    // Result register.
    logic                 out_valid_reg;
    outcome_t             outcome_reg, outcome_next;

    logic                 advance;
    logic                 accept;

    // Decision logic signals.
    logic [DL_W-1:0]      now_plus_limit;
    logic [DL_W-1:0]      dl_key;
    logic [DL_W-1:0]      dl_jump;
    logic                 same_pointer;
    logic                 rested;
    logic                 jumped;
    outcome_t             corner_res;

    // Corner geometry.
    logic signed [XC_W-1:0] x_s, y_s, cs_s, right_s, bottom_s;
    logic                   in_tl, in_tr, in_bl, in_br;
    logic [1:0]             corner_code;

    // Handshakes.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_DATA_W - 2){1'b0}}, outcome_reg};
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg     <= IDLE_W'(10);
            hot_span_reg       <= CSIZE_W'(10);
            rest_delay_reg     <= CDELAY_W'(5);
            screen_width_reg   <= SCREEN_W'(1024);
            screen_height_reg  <= SCREEN_W'(768);
            corner_actions_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDLE_LIMIT:     idle_limit_reg     <= cfg_data[IDLE_W-1:0];
                CFG_HOT_SPAN:       hot_span_reg       <= cfg_data[CSIZE_W-1:0];
                CFG_REST_DELAY:     rest_delay_reg     <= cfg_data[CDELAY_W-1:0];
                CFG_SCREEN_WIDTH:   screen_width_reg   <= cfg_data[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT:  screen_height_reg  <= cfg_data[SCREEN_W-1:0];
                CFG_CORNER_ACTIONS: corner_actions_reg <= cfg_data[ACTIONS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= s_tuser;
            now_reg      <= s_tdata[NOW_W-1:0];
            key_reg      <= s_tdata[32];
            force_reg    <= s_tdata[33];
            x_reg        <= s_tdata[49:34];
            y_reg        <= s_tdata[65:50];
            mask_reg     <= s_tdata[81:66];
        end
    end

    // Hot corner regions, tested in the order TL, TR, BL, BR.
    always_comb
    begin
        x_s      = XC_W'($signed(x_reg));
        y_s      = XC_W'($signed(y_reg));
        cs_s     = $signed({{(XC_W - CSIZE_W){1'b0}}, hot_span_reg});
        right_s  = $signed({{(XC_W - SCREEN_W){1'b0}}, screen_width_reg}) - cs_s
                   - XC_W'(1);
        bottom_s = $signed({{(XC_W - SCREEN_W){1'b0}}, screen_height_reg}) - cs_s
                   - XC_W'(1);
        in_tl = (x_s <= cs_s) && (x_s >= 0) && (y_s <= cs_s) && (y_s >= 0);
        in_tr = (x_s >= right_s) && (y_s <= cs_s);
        in_bl = (x_s <= cs_s) && (y_s >= bottom_s);
        in_br = (x_s >= right_s) && (y_s >= bottom_s);
        if (in_tl)
        begin
            corner_code = corner_actions_reg[1:0];
        end
        else if (in_tr)
        begin
            corner_code = corner_actions_reg[3:2];
        end
        else if (in_bl)
        begin
            corner_code = corner_actions_reg[5:4];
        end
        else if (in_br)
        begin
            corner_code = corner_actions_reg[7:6];
        end
        else
        begin
            corner_code = 2'd0;
        end
        case (corner_code)
            ACT_LOCK: corner_res = OUT_LOCK;
            ACT_SAVE: corner_res = OUT_SAVE;
            default:  corner_res = OUT_WAIT;
        endcase
    end

    // Decision logic for one beat.
    always_comb
    begin
        now_plus_limit = DL_W'(now_reg) + DL_W'(idle_limit_reg);
        dl_key         = key_reg ? now_plus_limit : deadline_reg;
        same_pointer   = (x_reg == last_x_reg) && (y_reg == last_y_reg)
                         && (mask_reg == last_mask_reg);
        rested         = RS_W'(now_plus_limit)
                         >= (RS_W'(dl_key) + RS_W'(rest_delay_reg));
        jumped         = ((now_reg > last_time_reg)
                          && ((now_reg - last_time_reg) > NOW_W'(JUMP_FWD)))
                         || ((last_time_reg > now_reg)
                          && ((last_time_reg - now_reg) > NOW_W'(JUMP_BACK)));

        armed_next     = armed_reg;
        deadline_next  = deadline_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        last_mask_next = last_mask_reg;
        last_time_next = last_time_reg;
        outcome_next   = OUT_WAIT;
        dl_jump        = dl_key;

        if (req_type_reg == REQ_START)
        begin
            armed_next     = 1'b1;
            deadline_next  = now_plus_limit;
            last_time_next = now_reg;
        end
        else if (armed_reg)
        begin
            if (force_reg)
            begin
                outcome_next = OUT_LOCK;
                armed_next   = 1'b0;
            end
            else
            begin
                // A still pointer may fire a corner; a moved one pushes the deadline.
                if (same_pointer)
                begin
                    if (rested)
                    begin
                        outcome_next = corner_res;
                    end
                    dl_jump = dl_key;
                end
                else
                begin
                    last_x_next    = x_reg;
                    last_y_next    = y_reg;
                    last_mask_next = mask_reg;
                    dl_jump        = now_plus_limit;
                end

                if (outcome_next != OUT_WAIT)
                begin
                    armed_next    = 1'b0;
                    deadline_next = dl_jump;
                end
                else
                begin
                    // Rearm on a clock jump, then test the deadline.
                    if (jumped)
                    begin
                        dl_jump = now_plus_limit;
                    end
                    last_time_next = now_reg;
                    if (DL_W'(now_reg) >= dl_jump)
                    begin
                        deadline_next = now_plus_limit;
                        outcome_next  = OUT_TIMEOUT;
                        armed_next    = 1'b0;
                    end
                    else
                    begin
                        deadline_next = dl_jump;
                    end
                end
            end
        end
    end

    // Timer state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            deadline_reg  <= '0;
            last_x_reg    <= '1;
            last_y_reg    <= '1;
            last_mask_reg <= '0;
            last_time_reg <= '0;
        end
        else if (advance)
        begin
            armed_reg     <= armed_next;
            deadline_reg  <= deadline_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            last_mask_reg <= last_mask_next;
            last_time_reg <= last_time_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            outcome_reg <= outcome_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/itohc_checker.sv -----
// Port-level checker for the inactivity timer with hot corners.
// Depends on itohc_pkg; bound to idle_timeout_with_hot_corners_unit below.
`default_nettype none

module itohc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [itohc_pkg::M_DATA_W-1:0]    m_tdata
);
    import itohc_pkg::*;

    // A stalled result beat holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A result appears only after an input beat was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result beat without a matching input beat");

    // The input side stalls only while a result waits downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the result side is free");

    // Fill bits above the outcome stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:2] == '0)
        else $error("result fill bits not zero");

endmodule

bind idle_timeout_with_hot_corners_unit itohc_checker u_itohc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb_idle_timeout_with_hot_corners_unit.sv -----
// Self-checking testbench for the inactivity timer with hot corners.
// Depends on itohc_pkg and the idle_timeout_with_hot_corners_unit RTL; a scoreboard
// class predicts each outcome beat while plain tasks drive the stream and register ports.
module tb_idle_timeout_with_hot_corners_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import itohc_pkg::*;

    localparam logic REQ_POLL      = ~REQ_START;
    localparam int   STALL_LIMIT   = 5000;
    localparam int   BEATS_PER_SET = 212;
    localparam int   NUM_SETS      = 8;

    // Predicts the outcome of every accepted request beat and checks result beats.
    class idle_timer_scoreboard;
        logic [IDLE_W-1:0]    idle_limit;
        logic [CSIZE_W-1:0]   hot_span;
        logic [CDELAY_W-1:0]  rest_delay;
        logic [SCREEN_W-1:0]  screen_width;
        logic [SCREEN_W-1:0]  screen_height;
        logic [ACTIONS_W-1:0] corner_actions;

        bit                   armed;
        longint unsigned      deadline;
        int                   last_x;
        int                   last_y;
        logic [MASK_W-1:0]    last_mask;
        longint unsigned      last_time;

        outcome_t             outcome_q[$];
        int                   errors;
        int                   n_results;
        int                   tally[4];

        function new();
            idle_limit     = 10;
            hot_span       = 10;
            rest_delay     = 5;
            screen_width   = 1024;
            screen_height  = 768;
            corner_actions = '0;
            armed          = 1'b0;
            deadline       = 0;
            last_x         = -1;
            last_y         = -1;
            last_mask      = '0;
            last_time      = 0;
            errors         = 0;
            n_results      = 0;
            foreach (tally[i])
                tally[i] = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_IDLE_LIMIT:     idle_limit     = value[IDLE_W-1:0];
                CFG_HOT_SPAN:       hot_span       = value[CSIZE_W-1:0];
                CFG_REST_DELAY:     rest_delay     = value[CDELAY_W-1:0];
                CFG_SCREEN_WIDTH:   screen_width   = value[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT:  screen_height  = value[SCREEN_W-1:0];
                CFG_CORNER_ACTIONS: corner_actions = value[ACTIONS_W-1:0];
                default: ;
            endcase
        endfunction

        // Action code 3 behaves like ignore.
        function outcome_t action_of(int corner);
            logic [1:0] code;
            code = 2'(corner_actions >> (2 * corner));
            if (code == ACT_LOCK)
                return OUT_LOCK;
            if (code == ACT_SAVE)
                return OUT_SAVE;
            return OUT_WAIT;
        endfunction

        // The first region holding the pointer decides, even when it is ignored.
        function outcome_t hot_corner(longint x, longint y);
            longint cs;
            longint right;
            longint bottom;
            cs     = hot_span;
            right  = longint'(screen_width) - cs - 1;
            bottom = longint'(screen_height) - cs - 1;
            if (x <= cs && x >= 0 && y <= cs && y >= 0)
                return action_of(0);
            if (x >= right && y <= cs)
                return action_of(1);
            if (x <= cs && y >= bottom)
                return action_of(2);
            if (x >= right && y >= bottom)
                return action_of(3);
            return OUT_WAIT;
        endfunction

        // A 32-bit clock plus a 17-bit limit never overflows 64 bits, so sums do not saturate.
        function void note_input(logic req, logic [NOW_IN_W-1:0] now_s, logic key,
                                 logic lock_req, int x, int y, logic [MASK_W-1:0] mask);
            outcome_t        res;
            longint unsigned now;
            longint unsigned fresh;
            res   = OUT_WAIT;
            now   = now_s;
            fresh = now + idle_limit;
            if (req == REQ_START) begin
                armed     = 1'b1;
                deadline  = fresh;
                last_time = now;
            end
            else if (armed) begin
                if (lock_req) begin
                    res   = OUT_LOCK;
                    armed = 1'b0;
                end
                else begin
                    if (key)
                        deadline = fresh;
                    if (x == last_x && y == last_y && mask == last_mask) begin
                        if (fresh >= deadline + rest_delay)
                            res = hot_corner(x, y);
                    end
                    else begin
                        last_x    = x;
                        last_y    = y;
                        last_mask = mask;
                        deadline  = fresh;
                    end
                    if (res != OUT_WAIT) begin
                        armed = 1'b0;
                    end
                    else begin
                        // A large clock jump in either direction rearms the deadline.
                        if ((now > last_time && now - last_time > JUMP_FWD) ||
                            (last_time > now && last_time - now > JUMP_BACK))
                            deadline = fresh;
                        last_time = now;
                        if (now >= deadline) begin
                            deadline = fresh;
                            res      = OUT_TIMEOUT;
                            armed    = 1'b0;
                        end
                    end
                end
            end
            outcome_q.push_back(res);
        endfunction

        function void check_result(logic [1:0] got);
            outcome_t exp;
            n_results++;
            if (!$isunknown(got))
                tally[got]++;
            if (outcome_q.size() == 0) begin
                errors++;
                $error("outcome beat with nothing pending: actual %0d", got);
                return;
            end
            exp = outcome_q.pop_front();
            if (got !== exp) begin
                errors++;
                $error("outcome mismatch: expected %0d (%s), actual %0d", exp, exp.name(), got);
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void report_leftovers();
            if (outcome_q.size() != 0) begin
                errors++;
                $error("outcome: %0d expected beats never arrived", outcome_q.size());
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    idle_timer_scoreboard  sb;

    // Pacing of both stream sides, in percent per cycle.
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    send_pct_tab[4] = '{0, 74, 0, 12};
    int                    recv_pct_tab[4] = '{0, 0, 74, 12};

    // Stimulus view of the register settings and the pointer.
    int                    cfg_lim;
    int                    cfg_cs;
    int                    cfg_dly;
    int                    cfg_w;
    int                    cfg_h;
    logic [31:0]           clock_now;
    logic [COORD_W-1:0]    cur_x;
    logic [COORD_W-1:0]    cur_y;
    logic [MASK_W-1:0]     cur_mask;
    int                    beats_sent;
    int                    settings_used;
    int                    stall_cycles;

    idle_timeout_with_hot_corners_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // now[31:0], key, lock request, x[15:0], y[15:0], mask[15:0], 0
        .s_tuser   (s_tuser),   // req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // outcome[1:0], 0
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // The receiver stalls at random from one falling edge to the next.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Every handshake is observed at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[33],
                              $signed(s_tdata[49:34]), $signed(s_tdata[65:50]),
                              s_tdata[81:66]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[1:0]);
        end
    end

    // Watchdog: ends the run after a long stretch with no beat moving anywhere.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("tb_idle_timeout_with_hot_corners_unit: errors");
            $finish;
        end
    end

    // Sends one request beat after a random gap; returns at the falling edge after it is taken.
    task automatic send_beat(logic req, logic [31:0] now_s, logic key, logic lock_req,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [MASK_W-1:0] mask);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, mask, y, x, lock_req, key, now_s};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic write_reg(cfg_index_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_config(int lim, int cs, int dly, int w, int h, int act);
        cfg_lim = lim;
        cfg_cs  = cs;
        cfg_dly = dly;
        cfg_w   = w;
        cfg_h   = h;
        write_reg(CFG_IDLE_LIMIT, lim);
        write_reg(CFG_HOT_SPAN, cs);
        write_reg(CFG_REST_DELAY, dly);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        write_reg(CFG_CORNER_ACTIONS, act);
        cfg_valid <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // Holds the request side idle until every predicted outcome has been received.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // One wait: a start beat followed by polls with random content until the wait ends.
    task automatic run_session();
        int r;
        int polls;
        int corner;
        int px;
        int py;
        logic key;
        logic lock_req;
        r = $urandom_range(99);
        if (r < 70)
            clock_now = clock_now + $urandom_range(0, 5);
        else if (r < 85)
            clock_now = $urandom;
        else if (r < 92)
            clock_now = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            clock_now = $urandom_range(0, 3);
        send_beat(REQ_START, clock_now, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  cur_x, cur_y, cur_mask);
        polls = $urandom_range(1, 14);
        for (int i = 0; i < polls && sb.armed; i++) begin
            // Time step: mostly small, sometimes around the delay, the limit or a jump.
            r = $urandom_range(99);
            if (r < 55)
                clock_now = clock_now + $urandom_range(0, 3);
            else if (r < 70)
                clock_now = clock_now + cfg_dly + $urandom_range(0, 1);
            else if (r < 82)
                clock_now = clock_now + cfg_lim - 1 + $urandom_range(0, 2);
            else if (r < 90)
                clock_now = clock_now + $urandom_range(119, 124);
            else if (r < 95)
                clock_now = clock_now - $urandom_range(119, 125);
            else
                clock_now = $urandom;
            // Pointer: mostly resting, often parked at a corner edge.
            r = $urandom_range(99);
            if (r >= 60 && r < 80) begin
                corner = $urandom_range(3);
                px = corner[0] ? cfg_w - cfg_cs - 1 + $urandom_range(cfg_cs, 0)
                               : $urandom_range(cfg_cs, 0);
                py = corner[1] ? cfg_h - cfg_cs - 1 + $urandom_range(cfg_cs, 0)
                               : $urandom_range(cfg_cs, 0);
                if ($urandom_range(9) == 0)
                    px = px - 1;
                if ($urandom_range(9) == 0)
                    py = py + 1;
                cur_x = px[COORD_W-1:0];
                cur_y = py[COORD_W-1:0];
            end
            else if (r >= 80 && r < 90) begin
                cur_x = cur_x + 16'd1;
            end
            else if (r >= 90) begin
                cur_x = 16'($urandom);
                cur_y = 16'($urandom);
            end
            if ($urandom_range(9) == 0)
                cur_mask = 16'($urandom);
            key      = ($urandom_range(9) == 0);
            lock_req = ($urandom_range(29) == 0);
            send_beat(REQ_POLL, clock_now, key, lock_req, cur_x, cur_y, cur_mask);
        end
        // Now and then a stray poll lands while the timer is disarmed.
        if ($urandom_range(6) == 0)
            send_beat(REQ_POLL, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic choose_config(int set_no);
        int lim;
        int act;
        case (set_no)
            2: apply_config(1, 0, 0, 1, 1, 0);
            5: apply_config(86400, 4095, 3600, 16384, 16384, 8'hFF);
            7: begin
                // Zero idle limit; top-left action forced to the unused code.
                act = $urandom_range(255);
                act[1:0] = 2'd3;
                apply_config(0, $urandom_range(8), $urandom_range(4),
                             $urandom_range(16, 200), $urandom_range(16, 200), act);
            end
            default: begin
                lim = $urandom_range(1, 40);
                apply_config(lim, $urandom_range(20), $urandom_range(lim),
                             $urandom_range(24, 1500), $urandom_range(24, 1200),
                             $urandom_range(255));
            end
        endcase
    endtask

    initial begin
        int set_start;
        bit pressure_done;
        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        beats_sent     = 0;
        settings_used  = 0;
        pressure_done  = 1'b0;
        cur_x          = '0;
        cur_y          = '0;
        cur_mask       = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: top-left lock, top-right save, bottom-left unused code.
        apply_config(10, 10, 5, 1024, 768, 8'h39);
        send_beat(REQ_POLL,  1000, 0, 0, 100, 100, 0);       // poll while disarmed
        send_beat(REQ_START, 1000, 0, 0, 100, 100, 0);
        send_beat(REQ_POLL,  1001, 0, 0, 5, 5, 0);
        send_beat(REQ_POLL,  1003, 0, 0, 5, 5, 0);
        send_beat(REQ_POLL,  1006, 0, 0, 5, 5, 0);           // rested in top-left
        send_beat(REQ_START, 1010, 0, 0, 0, 0, 0);
        send_beat(REQ_POLL,  1011, 0, 0, 1020, 3, 0);
        send_beat(REQ_POLL,  1016, 0, 0, 1020, 3, 0);        // rested in top-right
        send_beat(REQ_START, 1020, 0, 0, 0, 0, 0);
        send_beat(REQ_POLL,  1021, 0, 0, 3, 760, 0);
        send_beat(REQ_POLL,  1026, 0, 0, 3, 760, 0);         // corner with unused code
        send_beat(REQ_POLL,  1031, 0, 0, 3, 760, 0);         // deadline reached
        send_beat(REQ_START, 1040, 0, 0, 0, 0, 0);
        send_beat(REQ_POLL,  1041, 1, 1, 3, 760, 0);         // lock request wins over key
        send_beat(REQ_START, 1050, 0, 0, 0, 0, 0);
        send_beat(REQ_START, 1052, 0, 0, 0, 0, 0);           // start while armed
        send_beat(REQ_POLL,  1053, 1, 0, 3, 760, 0);
        send_beat(REQ_POLL,  1200, 0, 0, 3, 760, 0);         // forward jump
        send_beat(REQ_POLL,  1070, 0, 0, 3, 760, 0);         // backward jump
        send_beat(REQ_POLL,  1080, 0, 0, 3, 760, 0);
        send_beat(REQ_START, 2000, 0, 0, 0, 0, 0);
        send_beat(REQ_POLL,  2001, 0, 0, -5, 3, 0);          // negative x near top-left
        send_beat(REQ_POLL,  2006, 0, 0, -5, 3, 0);
        send_beat(REQ_POLL,  32'hFFFF_FFFF, 1, 0, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_beat(REQ_START, 32'hFFFF_FFFF, 0, 0, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_beat(REQ_POLL,  0, 0, 0, 16'h8000, 16'h7FFF, 16'h5A5A);
        send_beat(REQ_POLL,  5, 0, 0, 16'h8000, 16'h7FFF, 16'h5A5A);
        drain();

        // Random part: a new register setting and pacing mode for each set.
        clock_now = 5000;
        for (int set_no = 1; set_no <= NUM_SETS; set_no++) begin
            send_idle_pct  = send_pct_tab[set_no % 4];
            recv_stall_pct = recv_pct_tab[set_no % 4];
            choose_config(set_no);
            set_start = beats_sent;
            while (beats_sent - set_start < BEATS_PER_SET) begin
                run_session();
                if (set_no == 3 && !pressure_done && beats_sent - set_start >= 100) begin
                    drain();
                    pressure_done = 1'b1;
                end
            end
            drain();
        end

        repeat (6) @(negedge clk);
        sb.report_leftovers();
        $display("Run covered %0d request beats and %0d outcome beats over %0d register settings",
                 beats_sent, sb.n_results, settings_used);
        $display("Outcomes seen: wait %0d, timeout %0d, lock %0d, save %0d",
                 sb.tally[OUT_WAIT], sb.tally[OUT_TIMEOUT], sb.tally[OUT_LOCK],
                 sb.tally[OUT_SAVE]);
        if (sb.errors == 0)
            $display("tb_idle_timeout_with_hot_corners_unit: clean");
        else
            $display("tb_idle_timeout_with_hot_corners_unit: errors");
        $finish;
    end

endmodule
